// ----- sv/edmc_pkg.sv -----
package edmc_pkg;

   // encoder count width; targets and the serial passes follow from it (16 to 32)
   localparam int COUNT_BITS      = 32;
   localparam int COUNT_PORT_BITS = 32;
   localparam int AMOUNT_BITS     = 16;
   localparam int DRIVE_BITS      = 16;
   localparam int CPD_BITS        = 16;
   localparam int BYTE_BITS       = 8;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   // gain * remaining + min is COUNT_BITS + BYTE_BITS + 1 bits wide
   localparam int STEP_LAST = COUNT_BITS + BYTE_BITS;
   localparam int STEP_BITS = $clog2(STEP_LAST + 1);

   localparam logic [CPD_BITS-1:0]  CPD_RESET  = CPD_BITS'(10);
   localparam logic [BYTE_BITS-1:0] DPD_RESET  = BYTE_BITS'(1);
   localparam logic [BYTE_BITS-1:0] GAIN_RESET = BYTE_BITS'(1);
   localparam logic [BYTE_BITS-1:0] MIN_RESET  = BYTE_BITS'(30);

   typedef logic [STEP_BITS-1:0] step_type;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_STRAIGHT = 2'd1,
      CMD_TURN     = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_STRAIGHT = 2'd1,
      MODE_TURN     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_TICK,
      SEQ_FINISH
   } seq_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CPD  = 2'd0,
      REG_DPD  = 2'd1,
      REG_GAIN = 2'd2,
      REG_MIN  = 2'd3
   } reg_type;

   typedef struct packed {
      logic load;     // capture count, clear serial carries
      logic start;    // 1: target = count + offset, 0: remaining = target - count
      logic sel;      // this wheel takes the offset on a start
      logic shift;    // count and target advance one bit
      logic run;      // drive multiplier and min adder advance one bit
      logic low_win;  // drive bit falls inside the 16 output bits
   } lane_ctl_type;

endpackage

// ----- sv/edmc_lane.sv -----
module edmc_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  edmc_pkg::lane_ctl_type              ctl,
   input  logic [edmc_pkg::COUNT_BITS-1:0]     count,
   input  logic                                off_bit,
   input  logic [edmc_pkg::BYTE_BITS-1:0]      gain,
   input  logic [edmc_pkg::BYTE_BITS-1:0]      min_drive,
   output logic                                short_of,
   output logic [edmc_pkg::DRIVE_BITS-1:0]     drive
);

   logic [edmc_pkg::COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [edmc_pkg::COUNT_BITS-1:0] tgt_ff, tgt_in;
   logic                            ca_ff, ca_in;
   logic                            nz_ff, nz_in;
   logic [edmc_pkg::BYTE_BITS-1:0]  acc_ff, acc_in;
   logic [edmc_pkg::BYTE_BITS-1:0]  mn_ff, mn_in;
   logic                            cy_ff, cy_in;
   logic [edmc_pkg::DRIVE_BITS-1:0] drv_ff, drv_in;
   logic                            over_ff, over_in;

   logic [1:0]                      add_sum;
   logic [1:0]                      sub_dif;
   logic                            dbit;
   logic [edmc_pkg::BYTE_BITS:0]    prod;
   logic [1:0]                      drv_sum;

   always_comb begin
      add_sum = {1'b0, cnt_ff[0]} + {1'b0, ctl.sel & off_bit} + {1'b0, ca_ff};
      // bit 1 is the borrow
      sub_dif = {1'b0, tgt_ff[0]} - {1'b0, cnt_ff[0]} - {1'b0, ca_ff};
      dbit    = ctl.shift & ~ctl.start & sub_dif[0];
      prod    = {1'b0, acc_ff} + (dbit ? {1'b0, gain} : '0);
      drv_sum = {1'b0, prod[0]} + {1'b0, mn_ff[0]} + {1'b0, cy_ff};
   end

   always_comb begin
      cnt_in  = cnt_ff;
      tgt_in  = tgt_ff;
      ca_in   = ca_ff;
      nz_in   = nz_ff;
      acc_in  = acc_ff;
      mn_in   = mn_ff;
      cy_in   = cy_ff;
      drv_in  = drv_ff;
      over_in = over_ff;
      if (ctl.load) begin
         cnt_in  = count;
         ca_in   = 1'b0;
         nz_in   = 1'b0;
         acc_in  = '0;
         mn_in   = min_drive;
         cy_in   = 1'b0;
         over_in = 1'b0;
      end else begin
         if (ctl.shift) begin
            cnt_in = cnt_ff >> 1;
            // a tick rotates the target so it is whole again after the pass
            tgt_in = {(ctl.start ? add_sum[0] : tgt_ff[0]),
                      tgt_ff[edmc_pkg::COUNT_BITS-1:1]};
            ca_in  = ctl.start ? add_sum[1] : sub_dif[1];
            if (!ctl.start) begin
               nz_in = nz_ff | sub_dif[0];
            end
         end
         if (ctl.run) begin
            acc_in = prod[edmc_pkg::BYTE_BITS:1];
            mn_in  = mn_ff >> 1;
            cy_in  = drv_sum[1];
            if (ctl.low_win) begin
               drv_in = {drv_sum[0], drv_ff[edmc_pkg::DRIVE_BITS-1:1]};
            end else begin
               over_in = over_ff | drv_sum[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= '0;
      end else begin
         tgt_ff <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      ca_ff   <= ca_in;
      nz_ff   <= nz_in;
      acc_ff  <= acc_in;
      mn_ff   <= mn_in;
      cy_ff   <= cy_in;
      drv_ff  <= drv_in;
      over_ff <= over_in;
   end

   // no final borrow and a nonzero difference: count < target
   assign short_of = ~ca_ff & nz_ff;
   assign drive    = over_ff ? '1 : drv_ff;

endmodule

// ----- sv/encoder_drive_maneuver_control.sv -----
// Two-wheel encoder move controller. A straight command (1) sets both wheel targets to the
// current count plus counts_per_distance * distance (negative distance counts as zero); a
// turn command (2) adds distance_per_degree * counts_per_distance * |degrees| to the right
// wheel for positive degrees, else to the left, and is refused while a move is active.
// A tick (0) during a move returns each short wheel's drive, gain * remaining + min_drive
// saturated at 65535, and ends the move (done and stop) when the straight or turn rule says
// so. All arithmetic is bit serial, one bit per cycle: the serial pass of an accepted start or
// of a tick of an active move is as long as the widest product needs, gain times a COUNT_BITS
// remainder plus min_drive. Refused starts, idle ticks and command three skip the pass and
// answer straight into the output register. The result sits in an output register, so a
// pass may start while it waits.
// Configuration writes are taken at any time and must only be made while the block is idle.
module encoder_drive_maneuver_control (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_command,
   input  logic signed [edmc_pkg::AMOUNT_BITS-1:0] req_amount,
   input  logic [edmc_pkg::COUNT_PORT_BITS-1:0]    req_right_count,
   input  logic [edmc_pkg::COUNT_PORT_BITS-1:0]    req_left_count,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_accepted,
   output logic                                    rsp_done_res,
   output logic [edmc_pkg::DRIVE_BITS-1:0]         rsp_right_drive,
   output logic [edmc_pkg::DRIVE_BITS-1:0]         rsp_left_drive,
   output logic                                    rsp_stop_pulse,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [edmc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [edmc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int AB = edmc_pkg::AMOUNT_BITS;
   localparam int BB = edmc_pkg::BYTE_BITS;
   localparam int CB = edmc_pkg::CPD_BITS;

   edmc_pkg::seq_type  seq_ff, seq_in;
   edmc_pkg::step_type step_ff, step_in;
   edmc_pkg::mode_type mode_ff, mode_in;

   logic [CB-1:0] cpd_ff;
   logic [BB-1:0] dpd_ff, gain_ff, min_ff;

   // offset unit: serial magnitude into two chained serial-parallel multipliers
   logic [AB-1:0] amt_ff, amt_in;
   logic          neg_ff, neg_in;
   logic          seen_ff, seen_in;
   logic          zero_ff, zero_in;
   logic [BB-1:0] p1_ff, p1_in;
   logic [BB-1:0] acc1_ff, acc1_in;
   logic          m1_ff, m1_in;
   logic [CB-1:0] acc2_ff, acc2_in;
   logic          sel_r_ff, sel_r_in;
   logic          sel_l_ff, sel_l_in;
   logic          tick_ff, tick_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            acc_ff, done_ff, stop_ff;
   logic [edmc_pkg::DRIVE_BITS-1:0] rd_ff, ld_ff;

   edmc_pkg::cmd_type      cmd;
   edmc_pkg::lane_ctl_type ctl_base, ctl_r, ctl_l;
   logic                   active, pass_item, out_free, req_take;
   logic                   lane_load, off_run, imm_write, finish_write;
   logic                   mag_bit, off_bit, turn_right, go;
   logic [BB:0]            sum1;
   logic [CB:0]            sum2;
   logic                   r_short, l_short;
   logic [edmc_pkg::DRIVE_BITS-1:0] r_drive, l_drive;

   // command decode
   always_comb begin
      cmd    = edmc_pkg::cmd_type'(req_command);
      active = (mode_ff == edmc_pkg::MODE_STRAIGHT) || (mode_ff == edmc_pkg::MODE_TURN);
      case (cmd)
         edmc_pkg::CMD_TICK:     pass_item = active;
         edmc_pkg::CMD_STRAIGHT: pass_item = ~active;
         edmc_pkg::CMD_TURN:     pass_item = ~active;
         default:                pass_item = 1'b0;
      endcase
      out_free   = ~rsp_valid_ff | ~rsp_stall;
      req_stall  = (seq_ff != edmc_pkg::SEQ_IDLE) | (~pass_item & ~out_free);
      req_take   = req_valid & ~req_stall;
      turn_right = ~req_amount[AB-1] & (|req_amount);
   end

   // next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         edmc_pkg::SEQ_IDLE: begin
            if (req_take && pass_item) begin
               seq_in = (cmd == edmc_pkg::CMD_TICK) ? edmc_pkg::SEQ_TICK : edmc_pkg::SEQ_START;
            end
         end
         edmc_pkg::SEQ_START, edmc_pkg::SEQ_TICK: begin
            if (step_ff == edmc_pkg::step_type'(edmc_pkg::STEP_LAST)) begin
               seq_in = edmc_pkg::SEQ_FINISH;
            end
         end
         edmc_pkg::SEQ_FINISH: begin
            if (out_free) begin
               seq_in = edmc_pkg::SEQ_IDLE;
            end
         end
         default: seq_in = edmc_pkg::SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctl_base     = '0;
      step_in      = '0;
      off_run      = 1'b0;
      imm_write    = 1'b0;
      finish_write = 1'b0;
      lane_load    = 1'b0;
      case (seq_ff)
         edmc_pkg::SEQ_IDLE: begin
            lane_load     = req_take & pass_item;
            imm_write     = req_take & ~pass_item;
            ctl_base.load = lane_load;
         end
         edmc_pkg::SEQ_START: begin
            step_in        = step_ff + edmc_pkg::step_type'(1);
            off_run        = 1'b1;
            ctl_base.start = 1'b1;
            // offset bit k leaves the second multiplier at step k + 1
            ctl_base.shift = (step_ff >= edmc_pkg::step_type'(1)) &&
                             (step_ff <= edmc_pkg::step_type'(edmc_pkg::COUNT_BITS));
         end
         edmc_pkg::SEQ_TICK: begin
            step_in          = step_ff + edmc_pkg::step_type'(1);
            ctl_base.shift   = step_ff < edmc_pkg::step_type'(edmc_pkg::COUNT_BITS);
            ctl_base.run     = 1'b1;
            ctl_base.low_win = step_ff < edmc_pkg::step_type'(edmc_pkg::DRIVE_BITS);
         end
         edmc_pkg::SEQ_FINISH: begin
            finish_write = out_free;
         end
         default: begin
            step_in = '0;
         end
      endcase
      ctl_r     = ctl_base;
      ctl_r.sel = sel_r_ff;
      ctl_l     = ctl_base;
      ctl_l.sel = sel_l_ff;
   end

   // offset unit datapath
   always_comb begin
      // two's complement negate bit by bit: flip every bit above the lowest one
      mag_bit = (amt_ff[0] ^ (neg_ff & seen_ff)) & ~zero_ff;
      sum1    = {1'b0, acc1_ff} + (mag_bit ? {1'b0, p1_ff} : '0);
      sum2    = {1'b0, acc2_ff} + (m1_ff ? {1'b0, cpd_ff} : '0);
      off_bit = sum2[0];

      amt_in   = amt_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      zero_in  = zero_ff;
      p1_in    = p1_ff;
      acc1_in  = acc1_ff;
      m1_in    = m1_ff;
      acc2_in  = acc2_ff;
      sel_r_in = sel_r_ff;
      sel_l_in = sel_l_ff;
      tick_in  = tick_ff;
      if (lane_load) begin
         amt_in   = req_amount;
         neg_in   = req_amount[AB-1];
         seen_in  = 1'b0;
         zero_in  = (cmd == edmc_pkg::CMD_STRAIGHT) & req_amount[AB-1];
         p1_in    = (cmd == edmc_pkg::CMD_TURN) ? dpd_ff : BB'(1);
         acc1_in  = '0;
         m1_in    = 1'b0;
         acc2_in  = '0;
         sel_r_in = (cmd == edmc_pkg::CMD_STRAIGHT) | turn_right;
         sel_l_in = (cmd == edmc_pkg::CMD_STRAIGHT) | ~turn_right;
         tick_in  = cmd == edmc_pkg::CMD_TICK;
      end else if (off_run) begin
         // sign fill keeps the magnitude exact above the amount's width
         amt_in  = {amt_ff[AB-1], amt_ff[AB-1:1]};
         seen_in = seen_ff | amt_ff[0];
         acc1_in = sum1[BB:1];
         m1_in   = sum1[0];
         acc2_in = sum2[CB:1];
      end
   end

   edmc_lane u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_r),
      .count     (req_right_count[edmc_pkg::COUNT_BITS-1:0]),
      .off_bit   (off_bit),
      .gain      (gain_ff),
      .min_drive (min_ff),
      .short_of  (r_short),
      .drive     (r_drive)
   );

   edmc_lane u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_l),
      .count     (req_left_count[edmc_pkg::COUNT_BITS-1:0]),
      .off_bit   (off_bit),
      .gain      (gain_ff),
      .min_drive (min_ff),
      .short_of  (l_short),
      .drive     (l_drive)
   );

   // move mode and result
   always_comb begin
      go = (mode_ff == edmc_pkg::MODE_TURN) ? (r_short | l_short) : (r_short & l_short);
      mode_in = mode_ff;
      if (lane_load && (cmd == edmc_pkg::CMD_STRAIGHT)) begin
         mode_in = edmc_pkg::MODE_STRAIGHT;
      end else if (lane_load && (cmd == edmc_pkg::CMD_TURN)) begin
         mode_in = edmc_pkg::MODE_TURN;
      end else if (finish_write && tick_ff && !go) begin
         mode_in = edmc_pkg::MODE_IDLE;
      end
      if (imm_write || finish_write) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= edmc_pkg::SEQ_IDLE;
         step_ff      <= '0;
         mode_ff      <= edmc_pkg::MODE_IDLE;
         rsp_valid_ff <= 1'b0;
         cpd_ff       <= edmc_pkg::CPD_RESET;
         dpd_ff       <= edmc_pkg::DPD_RESET;
         gain_ff      <= edmc_pkg::GAIN_RESET;
         min_ff       <= edmc_pkg::MIN_RESET;
      end else begin
         seq_ff       <= seq_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (edmc_pkg::reg_type'(csr_index))
               edmc_pkg::REG_CPD:  cpd_ff  <= csr_wdata[CB-1:0];
               edmc_pkg::REG_DPD:  dpd_ff  <= csr_wdata[BB-1:0];
               edmc_pkg::REG_GAIN: gain_ff <= csr_wdata[BB-1:0];
               edmc_pkg::REG_MIN:  min_ff  <= csr_wdata[BB-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      amt_ff   <= amt_in;
      neg_ff   <= neg_in;
      seen_ff  <= seen_in;
      zero_ff  <= zero_in;
      p1_ff    <= p1_in;
      acc1_ff  <= acc1_in;
      m1_ff    <= m1_in;
      acc2_ff  <= acc2_in;
      sel_r_ff <= sel_r_in;
      sel_l_ff <= sel_l_in;
      tick_ff  <= tick_in;
      if (imm_write) begin
         acc_ff  <= 1'b0;
         done_ff <= cmd == edmc_pkg::CMD_TICK;
         rd_ff   <= '0;
         ld_ff   <= '0;
         stop_ff <= 1'b0;
      end else if (finish_write) begin
         acc_ff  <= ~tick_ff;
         done_ff <= tick_ff & ~go;
         stop_ff <= tick_ff & ~go;
         rd_ff   <= (tick_ff && go && r_short) ? r_drive : '0;
         ld_ff   <= (tick_ff && go && l_short) ? l_drive : '0;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_right_drive = rd_ff;
   assign rsp_left_drive  = ld_ff;
   assign rsp_stop_pulse  = stop_ff;

endmodule

// ----- sv/edmc_checker.sv -----
module edmc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_accepted,
   input logic                              rsp_done_res,
   input logic [edmc_pkg::DRIVE_BITS-1:0]   rsp_right_drive,
   input logic [edmc_pkg::DRIVE_BITS-1:0]   rsp_left_drive,
   input logic                              rsp_stop_pulse
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // an accepted start carries nothing else
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |->
         !rsp_done_res && !rsp_stop_pulse && rsp_right_drive == '0 && rsp_left_drive == '0)
      else $error("start item with tick fields set");

   // the stopping tick reports done and zero drive
   a_stop_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_pulse |->
         rsp_done_res && !rsp_accepted && rsp_right_drive == '0 && rsp_left_drive == '0)
      else $error("stop without done or with drive");

   // drive only while a move runs
   a_drive_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_right_drive != '0 || rsp_left_drive != '0) |->
         !rsp_done_res && !rsp_accepted)
      else $error("drive on a done or start item");

endmodule

bind encoder_drive_maneuver_control edmc_checker u_edmc_checker (.*);

// ----- bench/encoder_drive_maneuver_control_tb.sv -----
`timescale 1ns / 100ps

module encoder_drive_maneuver_control_tb;
   import edmc_pkg::*;

   localparam logic [1:0] CMD_IGNORED = 2'd3;
   localparam int PHASE_ITEMS = 340;
   localparam int DRAIN_CYCLES = COUNT_BITS + 30;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic                  accepted;
      logic                  done_res;
      logic [DRIVE_BITS-1:0] right_drive;
      logic [DRIVE_BITS-1:0] left_drive;
      logic                  stop_pulse;
   } move_result_type;

   class maneuver_scoreboard;
      logic [CPD_BITS-1:0]  cpd;
      logic [BYTE_BITS-1:0] dpd;
      logic [BYTE_BITS-1:0] gain;
      logic [BYTE_BITS-1:0] min_drive;
      mode_type             mode;
      count_type            rtarget;
      count_type            ltarget;
      move_result_type      expected_q[$];
      int                   errors;

      function new();
         cpd       = CPD_RESET;
         dpd       = DPD_RESET;
         gain      = GAIN_RESET;
         min_drive = MIN_RESET;
         mode      = MODE_IDLE;
         rtarget   = '0;
         ltarget   = '0;
         errors    = 0;
      endfunction

      function void write_reg(reg_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_CPD:  cpd       = data[CPD_BITS-1:0];
            REG_DPD:  dpd       = data[BYTE_BITS-1:0];
            REG_GAIN: gain      = data[BYTE_BITS-1:0];
            REG_MIN:  min_drive = data[BYTE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [DRIVE_BITS-1:0] wheel_drive(count_type count, count_type target,
                                                  output bit short_of);
         logic [63:0] d;
         short_of = count < target;
         if (!short_of)
            return '0;
         d = 64'(gain) * 64'(target - count) + 64'(min_drive);
         return (d > 64'hFFFF) ? 16'hFFFF : d[DRIVE_BITS-1:0];
      endfunction

      // predicts the response to one accepted item and queues it
      function void note_command(logic [1:0] cmd, logic [AMOUNT_BITS-1:0] amount,
                                 logic [COUNT_PORT_BITS-1:0] rc_in,
                                 logic [COUNT_PORT_BITS-1:0] lc_in);
         move_result_type r;
         logic [63:0] off;
         logic [16:0] mag;
         logic [DRIVE_BITS-1:0] rd, ld;
         count_type rc, lc;
         bit neg, rs, ls, go;
         r   = '0;
         rc  = count_type'(rc_in);
         lc  = count_type'(lc_in);
         neg = amount[AMOUNT_BITS-1];
         mag = neg ? (17'h10000 - {1'b0, amount}) : {1'b0, amount};
         case (cmd)
            CMD_STRAIGHT, CMD_TURN: begin
               if (mode == MODE_IDLE) begin
                  r.accepted = 1'b1;
                  if (cmd == CMD_STRAIGHT) begin
                     off     = neg ? 64'd0 : 64'(cpd) * 64'(mag);
                     rtarget = rc + count_type'(off);
                     ltarget = lc + count_type'(off);
                     mode    = MODE_STRAIGHT;
                  end else begin
                     off = 64'(dpd) * 64'(cpd) * 64'(mag);
                     // zero degrees falls to the left wheel
                     if (!neg && mag != 0) begin
                        rtarget = rc + count_type'(off);
                        ltarget = lc;
                     end else begin
                        ltarget = lc + count_type'(off);
                        rtarget = rc;
                     end
                     mode = MODE_TURN;
                  end
               end
            end
            CMD_TICK: begin
               if (mode == MODE_STRAIGHT || mode == MODE_TURN) begin
                  rd = wheel_drive(rc, rtarget, rs);
                  ld = wheel_drive(lc, ltarget, ls);
                  go = (mode == MODE_TURN) ? (rs || ls) : (rs && ls);
                  if (go) begin
                     r.right_drive = rd;
                     r.left_drive  = ld;
                  end else begin
                     mode         = MODE_IDLE;
                     r.done_res   = 1'b1;
                     r.stop_pulse = 1'b1;
                  end
               end else begin
                  r.done_res = 1'b1;
               end
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      function void check_result(move_result_type got);
         move_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: acc %0b done %0b rd %0d ld %0d stop %0b",
                        got.accepted, got.done_res, got.right_drive, got.left_drive,
                        got.stop_pulse);
            return;
         end
         e = expected_q.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected acc %0b done %0b rd %0d ld %0d stop %0b, ",
                         "got acc %0b done %0b rd %0d ld %0d stop %0b"},
                        e.accepted, e.done_res, e.right_drive, e.left_drive, e.stop_pulse,
                        got.accepted, got.done_res, got.right_drive, got.left_drive,
                        got.stop_pulse);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_command = '0;
   logic [AMOUNT_BITS-1:0]     req_amount = '0;
   logic [COUNT_PORT_BITS-1:0] req_right_count = '0;
   logic [COUNT_PORT_BITS-1:0] req_left_count = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_accepted;
   logic                       rsp_done_res;
   logic [DRIVE_BITS-1:0]      rsp_right_drive;
   logic [DRIVE_BITS-1:0]      rsp_left_drive;
   logic                       rsp_stop_pulse;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   maneuver_scoreboard sb;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int issued = 0;

   encoder_drive_maneuver_control DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_amount      (req_amount),
      .req_right_count (req_right_count),
      .req_left_count  (req_left_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_done_res    (rsp_done_res),
      .rsp_right_drive (rsp_right_drive),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_stop_pulse  (rsp_stop_pulse),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && sb != null && rsp_valid && !rsp_stall)
         sb.check_result({rsp_accepted, rsp_done_res, rsp_right_drive, rsp_left_drive,
                          rsp_stop_pulse});
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // encoder count around a target: mostly a little short, sometimes reached or random
   function automatic count_type count_near(count_type target);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return target - count_type'($urandom_range(1, 300));
         5, 6:          return target - count_type'($urandom_range(1, 100000));
         7:             return target;
         8:             return target + count_type'($urandom_range(0, 5));
         default:       return count_type'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [AMOUNT_BITS-1:0] amt,
                            input logic [COUNT_PORT_BITS-1:0] rc,
                            input logic [COUNT_PORT_BITS-1:0] lc);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_amount      <= amt;
      req_right_count <= rc;
      req_left_count  <= lc;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_command(cmd, amt, rc, lc);
      if (cmd != CMD_IGNORED)
         issued++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.expected_q.size() != 0);
   endtask

   task automatic write_csr(input reg_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // stop any move in progress, then load all four registers
   task automatic load_settings(input logic [CPD_BITS-1:0] cpd, input logic [7:0] dpd,
                                input logic [7:0] gain, input logic [7:0] mn);
      settle();
      if (sb.mode != MODE_IDLE) begin
         send_item(CMD_TICK, '0, '1, '1);
         settle();
      end
      write_csr(REG_CPD, cpd);
      write_csr(REG_DPD, 16'(dpd));
      write_csr(REG_GAIN, 16'(gain));
      write_csr(REG_MIN, 16'(mn));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [1:0]             cmd;
      logic [AMOUNT_BITS-1:0] amt;
      int                     ticks;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, ignored command, full straight with refused starts
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_IGNORED, 16'h8000, '1, '1);
      send_item(CMD_STRAIGHT, 16'h7FFF, '0, '0);
      send_item(CMD_STRAIGHT, 16'd5, 32'd1, 32'd2);
      send_item(CMD_TURN, 16'd10, 32'd3, 32'd4);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_TICK, '0, sb.rtarget - 1, sb.ltarget - 35);
      send_item(CMD_TICK, '0, sb.rtarget, sb.ltarget - 1);
      // negative distance straight ends on the next tick
      send_item(CMD_STRAIGHT, 16'hFFFF, '1, 32'd12345);
      send_item(CMD_TICK, '0, '1, 32'd12345);
      // right turn whose target wraps past zero
      send_item(CMD_TURN, 16'd90, 32'hFFFF_FFF0, 32'd777);
      send_item(CMD_TICK, '0, 32'h100, 32'd777);
      send_item(CMD_TICK, '0, 32'hFFFF_FFF0, 32'd777);
      // most negative degrees, left wheel
      send_item(CMD_TURN, 16'h8000, 32'd5, '0);
      send_item(CMD_TICK, '0, 32'd5, sb.ltarget - 1);
      send_item(CMD_TICK, '0, 32'd5, sb.ltarget);
      // zero degrees picks the left wheel with no offset
      send_item(CMD_TURN, '0, $urandom, $urandom);
      send_item(CMD_TICK, '0, sb.rtarget, sb.ltarget);
      send_item(CMD_IGNORED, 16'h7FFF, $urandom, $urandom);
      // zero gain and zero floor: short wheel gets no drive but keeps moving
      settle();
      write_csr(REG_GAIN, '0);
      write_csr(REG_MIN, '0);
      csr_valid <= 1'b0;
      send_item(CMD_STRAIGHT, 16'd1, '0, '0);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_TICK, '0, '1, '1);
      settle();
      write_csr(REG_CPD, '0);
      csr_valid <= 1'b0;
      send_item(CMD_STRAIGHT, 16'd100, $urandom, $urandom);
      send_item(CMD_TICK, '0, sb.rtarget, sb.ltarget);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: load_settings(16'($urandom_range(1, 20)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
            1: load_settings(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
            2: load_settings(16'($urandom_range(1, 16)), 8'd0, 8'd0, 8'd0);
            default: load_settings(16'($urandom), 8'($urandom),
                                   8'($urandom_range(1, 255)), 8'd0);
         endcase
         req_idle_pct  = (p == 1) ? 85 : (p == 3) ? 17 : 0;
         rsp_stall_pct = (p == 2) ? 85 : (p == 3) ? 17 : 0;
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
               cmd = $urandom_range(0, 1) ? CMD_STRAIGHT : CMD_TURN;
               case ($urandom_range(0, 5))
                  0, 1, 2: amt = 16'($urandom_range(0, 40));
                  3:       amt = 16'(0 - $urandom_range(0, 40));
                  4:       amt = 16'($urandom);
                  default: amt = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               endcase
               send_item(cmd, amt, $urandom, $urandom);
               ticks = $urandom_range(1, 10);
               for (int i = 0; i < ticks; i++) begin
                  // a stray start or an ignored command in the middle of a move
                  if ($urandom_range(0, 9) == 0)
                     send_item(2'($urandom_range(1, 3)), 16'($urandom), $urandom, $urandom);
                  send_item(CMD_TICK, 16'($urandom), count_near(sb.rtarget),
                            count_near(sb.ltarget));
               end
            end else begin
               send_item(2'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
